[sv/particle_sensor_frame_parser_macros.svh]
// assertion macros used by the parser rtl
`ifndef PARTICLE_SENSOR_FRAME_PARSER_MACROS_SVH
`define PARTICLE_SENSOR_FRAME_PARSER_MACROS_SVH

// clocked check, switched off while reset is high
`define PSFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also runs through reset
`define PSFP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/psfp_pkg.sv]
// constants and widths for the particle sensor frame parser
package psfp_pkg;

  localparam int COUNTER_WIDTH_DEF = 16;

  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 16;
  localparam int OUT_DATA_W = 4 * VALUE_W;

  localparam logic [BYTE_W-1:0] HDR_BYTE  = 8'hAA;
  localparam logic [BYTE_W-1:0] CMD_BYTE  = 8'hC0;
  localparam logic [BYTE_W-1:0] TAIL_BYTE = 8'hAB;

  localparam int STATE_W = 4;
  localparam logic [STATE_W-1:0] ST_HEADER  = 4'd0;
  localparam logic [STATE_W-1:0] ST_COMMAND = 4'd1;
  localparam logic [STATE_W-1:0] ST_D1      = 4'd2;
  localparam logic [STATE_W-1:0] ST_D2      = 4'd3;
  localparam logic [STATE_W-1:0] ST_D3      = 4'd4;
  localparam logic [STATE_W-1:0] ST_D4      = 4'd5;
  localparam logic [STATE_W-1:0] ST_D5      = 4'd6;
  localparam logic [STATE_W-1:0] ST_D6      = 4'd7;
  localparam logic [STATE_W-1:0] ST_CKSUM   = 4'd8;
  localparam logic [STATE_W-1:0] ST_TAIL    = 4'd9;

endpackage

[sv/particle_sensor_frame_parser.sv]
// particle sensor frame parser: byte stream in, reading and counters out
//
// Parses ten-byte sensor frames from a stream of received serial bytes: header
// 0xAA, command 0xC0, six data bytes, a sum-of-data checksum and tail 0xAB.
// Every input transaction (one byte) yields exactly one output transaction.
// The output tdata carries the current PM2.5 and PM10 registers (written as
// their data bytes arrive, so they can show a half-built value mid-frame) and
// the low 16 bits of the bad-character and checksum-failure counters, which
// are COUNTER_WIDTH bits wide and wrap. tuser is high on the transaction of a
// checksum byte that matched. A byte is taken every clock: it lands in an
// input register, is parsed by one pass of logic (a byte compare and an 8-bit
// add) and its result goes to an output register, so throughput is one byte
// per cycle while the output side keeps up. Both registers hold under
// backpressure; tready is high whenever the input register is empty or moving
// on. Reset is synchronous and returns the parser to header hunting with all
// values and counters at zero.
module particle_sensor_frame_parser #(
  parameter int COUNTER_WIDTH = psfp_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input byte stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [psfp_pkg::BYTE_W-1:0]   s_axis_tdata,   // [7:0] rx_byte
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [15:0] pm25_value, [31:16] pm10_value, [47:32] bad_char_count,
  // [63:48] checksum_fail_count
  output logic [psfp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tuser    // [0] reading_valid
);
  import psfp_pkg::*;

  `include "particle_sensor_frame_parser_macros.svh"

  // input register
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;

  // parser state
  logic [STATE_W-1:0]       state, state_next;
  logic [BYTE_W-1:0]        running_sum, running_sum_next;
  logic [VALUE_W-1:0]       pm25, pm25_next;
  logic [VALUE_W-1:0]       pm10, pm10_next;
  logic [COUNTER_WIDTH-1:0] bad_count, bad_count_next;
  logic [COUNTER_WIDTH-1:0] cksum_fail, cksum_fail_next;
  logic                     reading_next;

  // output register
  logic                  out_valid;
  logic                  out_reading;
  logic [VALUE_W-1:0]    out_pm25, out_pm10, out_bad, out_fail;

  // counters seen through the 16-bit output view
  logic [VALUE_W-1:0] bad_view, fail_view;

  logic out_advance;  // output register can take a new result
  logic step;         // input byte is parsed this cycle

  assign out_advance   = !out_valid || m_axis_tready;
  assign step          = in_valid && out_advance;
  assign s_axis_tready = !in_valid || out_advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  // frame parser, one byte per pass
  always_comb begin
    state_next       = state;
    running_sum_next = running_sum;
    pm25_next        = pm25;
    pm10_next        = pm10;
    bad_count_next   = bad_count;
    cksum_fail_next  = cksum_fail;
    reading_next     = 1'b0;
    case (state)
      ST_COMMAND: begin
        if (in_byte == CMD_BYTE) begin
          state_next = ST_D1;
        end else begin
          bad_count_next = bad_count + 1'b1;
          state_next     = ST_HEADER;
        end
      end
      ST_D1: begin
        pm25_next        = {8'h00, in_byte};
        running_sum_next = in_byte;
        state_next       = ST_D2;
      end
      ST_D2: begin
        pm25_next        = pm25 | {in_byte, 8'h00};
        running_sum_next = running_sum + in_byte;
        state_next       = ST_D3;
      end
      ST_D3: begin
        pm10_next        = {8'h00, in_byte};
        running_sum_next = running_sum + in_byte;
        state_next       = ST_D4;
      end
      ST_D4: begin
        pm10_next        = pm10 | {in_byte, 8'h00};
        running_sum_next = running_sum + in_byte;
        state_next       = ST_D5;
      end
      ST_D5: begin
        running_sum_next = running_sum + in_byte;
        state_next       = ST_D6;
      end
      ST_D6: begin
        running_sum_next = running_sum + in_byte;
        state_next       = ST_CKSUM;
      end
      ST_CKSUM: begin
        if (in_byte != running_sum) begin
          cksum_fail_next = cksum_fail + 1'b1;
          state_next      = ST_HEADER;
        end else begin
          reading_next = 1'b1;
          state_next   = ST_TAIL;
        end
      end
      ST_TAIL: begin
        // any tail byte ends the frame, a wrong one is also counted
        if (in_byte != TAIL_BYTE) begin
          bad_count_next = bad_count + 1'b1;
        end
        state_next = ST_HEADER;
      end
      default: begin
        // header hunting, also taken by unused codes
        if (in_byte == HDR_BYTE) begin
          state_next = ST_COMMAND;
        end else begin
          bad_count_next = bad_count + 1'b1;
          state_next     = ST_HEADER;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_HEADER;
      running_sum <= '0;
      pm25        <= '0;
      pm10        <= '0;
      bad_count   <= '0;
      cksum_fail  <= '0;
    end else if (step) begin
      state       <= state_next;
      running_sum <= running_sum_next;
      pm25        <= pm25_next;
      pm10        <= pm10_next;
      bad_count   <= bad_count_next;
      cksum_fail  <= cksum_fail_next;
    end
  end

  // counters are shown as their low 16 bits, zero-extended when narrower
  assign bad_view  = VALUE_W'(bad_count_next);
  assign fail_view = VALUE_W'(cksum_fail_next);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_reading <= reading_next;
      out_pm25    <= pm25_next;
      out_pm10    <= pm10_next;
      out_bad     <= bad_view;
      out_fail    <= fail_view;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_reading;
  assign m_axis_tdata  = {out_fail, out_bad, out_pm10, out_pm25};

  // a shown reading means the parser is now waiting for the tail byte
  `PSFP_ASSERT(a_reading_then_tail, (out_valid && out_reading) |-> (state == ST_TAIL),
    "reading flagged while parser is not at the tail byte")

  // parser state and counters only move when a byte is parsed
  `PSFP_ASSERT(a_hold_without_step,
    !step |=> ($stable(state) && $stable(bad_count) && $stable(cksum_fail)),
    "parser state changed without a parsed byte")

  // state never leaves the range of frame positions
  `PSFP_ASSERT(a_state_range, state <= ST_TAIL, "parser state beyond tail position")

  // reset empties both registers and restarts header hunting
  `PSFP_ASSERT_ALWAYS(a_reset_clears,
    rst |=> (state == ST_HEADER && !in_valid && !out_valid),
    "reset did not clear the parser")

endmodule

[tb/particle_sensor_frame_parser_tb.sv]
// self-checking testbench for the particle sensor frame parser
`timescale 1ns / 100ps

module particle_sensor_frame_parser_tb;
  import psfp_pkg::*;

  // one output transaction as seen by the checker
  typedef struct packed {
    logic                valid;
    logic [VALUE_W-1:0]  pm25;
    logic [VALUE_W-1:0]  pm10;
    logic [VALUE_W-1:0]  bad;
    logic [VALUE_W-1:0]  fail;
  } reading_t;

  // directed stimulus row: the byte, a flag for a typed-in result, the result
  typedef struct packed {
    logic [BYTE_W-1:0] rx;
    logic              typed;
    reading_t          res;
  } dir_row_t;

  localparam int N_DIR = 23;
  localparam int N_ITEMS = 550;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam logic [65:0] PREDICT = '0;

  // directed rows: error paths, a good frame with all-ones pm25 and a frame
  // with all-ones pm10 whose checksum fails; typed results only at a glance
  localparam dir_row_t DIR_ROWS [0:N_DIR-1] = '{
    {8'h00, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0001, 16'h0000}, // bad header
    {HDR_BYTE, PREDICT},
    {8'hAA, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0002, 16'h0000}, // header as command
    {HDR_BYTE, PREDICT},
    {CMD_BYTE, PREDICT},
    {8'hFF, PREDICT},
    {8'hFF, PREDICT},                                             // pm25 high byte; the row above shows it half built
    {8'h00, PREDICT},
    {8'h00, PREDICT},
    {8'h01, PREDICT},
    {8'h02, PREDICT},
    {8'h01, 1'b1, 1'b1, 16'hFFFF, 16'h0000, 16'h0002, 16'h0000}, // checksum match
    {8'h55, 1'b1, 1'b0, 16'hFFFF, 16'h0000, 16'h0003, 16'h0000}, // wrong tail
    {HDR_BYTE, PREDICT},
    {CMD_BYTE, PREDICT},
    {8'h00, PREDICT},
    {8'h00, PREDICT},
    {8'hFF, PREDICT},
    {8'hFF, PREDICT},
    {8'h00, PREDICT},
    {8'h00, PREDICT},
    {8'hFF, 1'b1, 1'b0, 16'h0000, 16'hFFFF, 16'h0003, 16'h0001}, // checksum mismatch
    {TAIL_BYTE, PREDICT}                                          // tail while hunting
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [BYTE_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  // parser state mirrored by the predictor
  logic [STATE_W-1:0] frame_state;
  logic [BYTE_W-1:0]  data_sum;
  logic [VALUE_W-1:0] pm25_q, pm10_q, bad_q, fail_q;

  reading_t pending_readings[$];
  int bytes_sent = 0;
  int mismatches = 0;
  bit idle_on = 1'b1;
  bit long_hold = 1'b0;

  particle_sensor_frame_parser uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // advance the mirrored parser by one byte and return the output it implies
  function automatic reading_t parse_byte(input logic [BYTE_W-1:0] b);
    reading_t r;
    logic hit;
    hit = 1'b0;
    case (frame_state)
      ST_COMMAND: begin
        if (b == CMD_BYTE) begin
          frame_state = ST_D1;
        end else begin
          bad_q = bad_q + 1'b1;
          frame_state = ST_HEADER;  // the byte is not retried as a header
        end
      end
      ST_D1: begin
        pm25_q = {8'h00, b};
        data_sum = b;
        frame_state = ST_D2;
      end
      ST_D2: begin
        pm25_q[15:8] = b;
        data_sum = data_sum + b;
        frame_state = ST_D3;
      end
      ST_D3: begin
        pm10_q = {8'h00, b};
        data_sum = data_sum + b;
        frame_state = ST_D4;
      end
      ST_D4: begin
        pm10_q[15:8] = b;
        data_sum = data_sum + b;
        frame_state = ST_D5;
      end
      ST_D5: begin
        data_sum = data_sum + b;
        frame_state = ST_D6;
      end
      ST_D6: begin
        data_sum = data_sum + b;
        frame_state = ST_CKSUM;
      end
      ST_CKSUM: begin
        if (b != data_sum) begin
          fail_q = fail_q + 1'b1;
          frame_state = ST_HEADER;
        end else begin
          hit = 1'b1;
          frame_state = ST_TAIL;
        end
      end
      ST_TAIL: begin
        if (b != TAIL_BYTE) bad_q = bad_q + 1'b1;
        frame_state = ST_HEADER;
      end
      default: begin
        if (b == HDR_BYTE) begin
          frame_state = ST_COMMAND;
        end else begin
          bad_q = bad_q + 1'b1;
          frame_state = ST_HEADER;
        end
      end
    endcase
    r.valid = hit;
    r.pm25 = pm25_q;
    r.pm10 = pm10_q;
    r.bad = bad_q;
    r.fail = fail_q;
    return r;
  endfunction

  // offer one byte, maybe after an idle burst; queue its result on acceptance
  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic typed,
                           input reading_t typed_res);
    reading_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk); while (!s_axis_tready);
    r = parse_byte(b);
    pending_readings.push_back(typed ? typed_res : r);
    bytes_sent++;
  endtask

  // stop offering and wait until every queued result has come out
  task automatic drain_readings();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] data_byte();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // output side: random stall bursts plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // compare each output transaction with the oldest queued result
  always @(posedge clk) begin
    reading_t want;
    reading_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
             m_axis_tdata[47:32], m_axis_tdata[63:48]};
      if (pending_readings.size() == 0) begin
        $error("output transaction with no result queued");
        mismatches++;
      end else begin
        want = pending_readings.pop_front();
        if (got.valid !== want.valid) begin
          $error("reading_valid: expected %0h, got %0h", want.valid, got.valid);
          mismatches++;
        end
        if (got.pm25 !== want.pm25) begin
          $error("pm25_value: expected %0h, got %0h", want.pm25, got.pm25);
          mismatches++;
        end
        if (got.pm10 !== want.pm10) begin
          $error("pm10_value: expected %0h, got %0h", want.pm10, got.pm10);
          mismatches++;
        end
        if (got.bad !== want.bad) begin
          $error("bad_char_count: expected %0h, got %0h", want.bad, got.bad);
          mismatches++;
        end
        if (got.fail !== want.fail) begin
          $error("checksum_fail_count: expected %0h, got %0h", want.fail, got.fail);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [BYTE_W-1:0] burst[$];
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] tmp;
    int kind;
    bit hold_done;
    bit pause_done;
    hold_done = 1'b0;
    pause_done = 1'b0;
    frame_state = ST_HEADER;
    data_sum = '0;
    pm25_q = '0;
    pm10_q = '0;
    bad_q = '0;
    fail_q = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIR_ROWS[i]) push_byte(DIR_ROWS[i].rx, DIR_ROWS[i].typed, DIR_ROWS[i].res);

    // random part: mostly well-formed frames, the rest broken frames and noise
    while (bytes_sent < N_ITEMS) begin
      if (!hold_done && bytes_sent >= 200) begin
        long_hold = 1'b1;  // sender keeps offering while the output is held
        hold_done = 1'b1;
      end
      if (!pause_done && bytes_sent >= 350) begin
        drain_readings();
        pause_done = 1'b1;
      end
      if (bytes_sent >= N_ITEMS - 60) idle_on = 1'b0;

      burst.delete();
      kind = $urandom_range(0, 99);
      if (kind < 72) begin
        // full frame: good, checksum off, or tail off
        burst.push_back(HDR_BYTE);
        burst.push_back(CMD_BYTE);
        sum = '0;
        repeat (6) begin
          tmp = data_byte();
          sum = sum + tmp;
          burst.push_back(tmp);
        end
        if (kind >= 55 && kind < 65) sum = sum + BYTE_W'($urandom_range(1, 255));
        burst.push_back(sum);
        tmp = TAIL_BYTE;
        if (kind >= 65) begin
          do tmp = BYTE_W'($urandom_range(0, 255)); while (tmp == TAIL_BYTE);
        end
        burst.push_back(tmp);
      end else if (kind < 80) begin
        // wrong command byte, sometimes a second header
        burst.push_back(HDR_BYTE);
        do tmp = ($urandom_range(0, 1) == 0) ? HDR_BYTE : BYTE_W'($urandom_range(0, 255));
        while (tmp == CMD_BYTE);
        burst.push_back(tmp);
      end else if (kind < 88) begin
        // frame cut short
        burst.push_back(HDR_BYTE);
        burst.push_back(CMD_BYTE);
        repeat ($urandom_range(0, 5)) burst.push_back(data_byte());
      end else begin
        // line noise
        repeat ($urandom_range(1, 4)) begin
          burst.push_back(($urandom_range(0, 3) == 0) ? HDR_BYTE
                                                      : BYTE_W'($urandom_range(0, 255)));
        end
      end
      foreach (burst[i]) push_byte(burst[i], 1'b0, '0);
    end

    drain_readings();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
